// File: rtl/cbq_pkg.sv
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types and constants of the coalescing batch queue: request and
// result payloads, the stored entry layout, codes and controller states.
// ----------------------------------------------------------------------------
package cbq_pkg;

	localparam int QueueDepthDefault = 32;
	localparam int BatchW            = 16;
	localparam logic [BatchW-1:0] BatchNone = '1;

	typedef enum logic [1:0] {
		REQ_ENQUEUE = 2'd0,
		REQ_TICK    = 2'd1,
		REQ_DROP    = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		CAUSE_FULL = 2'd0,
		CAUSE_SIZE = 2'd1,
		CAUSE_TIME = 2'd2
	} cause_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INSERT,
		ST_DRAIN_RD,
		ST_DRAIN,
		ST_SCAN_RD,
		ST_SCAN,
		ST_DROP_RD,
		ST_DROP_CHK,
		ST_DROP_MOV
	} state_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [1:0]        op_code;
		logic [31:0]       record_tag;
		logic [15:0]       mode_bits;
		logic [15:0]       owner_id;
		logic [BatchW-1:0] batch_limit;
		logic [31:0]       wait_limit;
		logic [31:0]       now_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]  out_op_code;
		logic [31:0] out_record_tag;
		logic [15:0] out_mode_bits;
		logic [15:0] out_owner_id;
		logic [1:0]  drain_cause;
		logic        last_of_drain;
	} rsp_t;

	typedef struct packed {
		logic [1:0]        op_code;
		logic [31:0]       record_tag;
		logic [15:0]       mode_bits;
		logic [15:0]       owner_id;
		logic [BatchW-1:0] batch_limit;
		logic [31:0]       wait_limit;
		logic [31:0]       stamp;
	} entry_t;

endpackage

// File: rtl/coalescing_batch_queue_core.sv
// ----------------------------------------------------------------------------
// coalescing_batch_queue_core
// Parks requests in a slot memory and drains them as a batch on a full
// queue, on a size threshold or on an expired wait; drops entries by owner.
// ----------------------------------------------------------------------------
// One request is worked at a time; req_stall is low only while the block is
// idle. All entries sit in a single memory with one read and one write port
// and a registered read, and that read port sets the pace: an enqueue that
// drains nothing passes through the insert state only; a drain reads the
// first slot and then moves one result a cycle when rsp is not stalled; a tick
// scans the entries one by one before any drain; a drop checks each entry
// and moves the last slot down into each removed one. An enqueue into a full
// queue first drains it, then inserts, and may then trigger another drain.
module coalescing_batch_queue_core #(
	parameter int QUEUE_DEPTH = cbq_pkg::QueueDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cbq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cbq_pkg::rsp_t rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int BW    = cbq_pkg::BatchW;

	cbq_pkg::state_t state_q, state_d;
	cbq_pkg::req_t   req_q;
	cbq_pkg::cause_t cause_q;
	cbq_pkg::entry_t mem [QUEUE_DEPTH];
	cbq_pkg::entry_t rdata_s1;
	cbq_pkg::entry_t wr_data;
	cbq_pkg::rsp_t   rsp_q;

	logic [CNT_W-1:0] count_q, idx_q, cnt_last, idx_next;
	logic [BW-1:0]    min_q, min_acc_q, batch_eff, ins_min, drop_min, count_inc;
	logic [31:0]      elapsed;
	logic             rd_en, wr_en, load_out, out_free;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic             is_last, size_hit, scan_hit, drop_match, rsp_valid_q;

	assign cnt_last   = count_q - CNT_W'(1);
	assign idx_next   = idx_q + CNT_W'(1);
	assign is_last    = (idx_q == cnt_last);
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign batch_eff  = (req_q.batch_limit == '0) ? BW'(1) : req_q.batch_limit;
	assign ins_min    = (batch_eff < min_q) ? batch_eff : min_q;
	assign count_inc  = BW'(count_q) + BW'(1);
	assign size_hit   = (count_inc >= ins_min);
	assign elapsed    = req_q.now_ms - rdata_s1.stamp;
	assign scan_hit   = (elapsed >= rdata_s1.wait_limit);
	assign drop_match = (rdata_s1.owner_id == req_q.owner_id);
	assign drop_min   = (rdata_s1.batch_limit < min_acc_q) ? rdata_s1.batch_limit : min_acc_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cbq_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (req.req_type)
						cbq_pkg::REQ_ENQUEUE: begin
							state_d = (count_q == CNT_W'(QUEUE_DEPTH)) ?
								cbq_pkg::ST_DRAIN_RD : cbq_pkg::ST_INSERT;
						end
						cbq_pkg::REQ_TICK: begin
							state_d = (count_q != '0) ? cbq_pkg::ST_SCAN_RD : cbq_pkg::ST_IDLE;
						end
						cbq_pkg::REQ_DROP: begin
							state_d = (count_q != '0) ? cbq_pkg::ST_DROP_RD : cbq_pkg::ST_IDLE;
						end
						default: state_d = cbq_pkg::ST_IDLE;
					endcase
				end
			end
			cbq_pkg::ST_INSERT: begin
				state_d = size_hit ? cbq_pkg::ST_DRAIN_RD : cbq_pkg::ST_IDLE;
			end
			cbq_pkg::ST_DRAIN_RD: state_d = cbq_pkg::ST_DRAIN;
			cbq_pkg::ST_DRAIN: begin
				if (out_free && is_last) begin
					// a full-queue drain still owes the insert
					state_d = (cause_q == cbq_pkg::CAUSE_FULL) ?
						cbq_pkg::ST_INSERT : cbq_pkg::ST_IDLE;
				end
			end
			cbq_pkg::ST_SCAN_RD: state_d = cbq_pkg::ST_SCAN;
			cbq_pkg::ST_SCAN: begin
				if (scan_hit) begin
					state_d = cbq_pkg::ST_DRAIN_RD;
				end else if (is_last) begin
					state_d = cbq_pkg::ST_IDLE;
				end
			end
			cbq_pkg::ST_DROP_RD: state_d = cbq_pkg::ST_DROP_CHK;
			cbq_pkg::ST_DROP_CHK: begin
				if (is_last) begin
					state_d = cbq_pkg::ST_IDLE;
				end else if (drop_match) begin
					state_d = cbq_pkg::ST_DROP_MOV;
				end
			end
			cbq_pkg::ST_DROP_MOV: state_d = cbq_pkg::ST_DROP_RD;
			default: state_d = cbq_pkg::ST_IDLE;
		endcase
	end

	// memory and output control
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = idx_q[IDX_W-1:0];
		wr_en    = 1'b0;
		wr_addr  = idx_q[IDX_W-1:0];
		wr_data  = rdata_s1;
		load_out = 1'b0;
		case (state_q)
			cbq_pkg::ST_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = count_q[IDX_W-1:0];
				wr_data = '{op_code:     req_q.op_code,
				            record_tag:  req_q.record_tag,
				            mode_bits:   req_q.mode_bits,
				            owner_id:    req_q.owner_id,
				            batch_limit: batch_eff,
				            wait_limit:  req_q.wait_limit,
				            stamp:       req_q.now_ms};
			end
			cbq_pkg::ST_DRAIN_RD, cbq_pkg::ST_SCAN_RD, cbq_pkg::ST_DROP_RD: begin
				rd_en = 1'b1;
			end
			cbq_pkg::ST_DRAIN: begin
				load_out = out_free;
				// fetch the next slot as this one transfers out
				rd_en    = out_free && !is_last;
				rd_addr  = idx_next[IDX_W-1:0];
			end
			cbq_pkg::ST_SCAN: begin
				rd_en   = !scan_hit && !is_last;
				rd_addr = idx_next[IDX_W-1:0];
			end
			cbq_pkg::ST_DROP_CHK: begin
				rd_en   = !is_last;
				// on a match fetch the last slot to move it down
				rd_addr = drop_match ? cnt_last[IDX_W-1:0] : idx_next[IDX_W-1:0];
			end
			cbq_pkg::ST_DROP_MOV: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cbq_pkg::ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (load_out) begin
			rsp_q <= '{out_op_code:    rdata_s1.op_code,
			           out_record_tag: rdata_s1.record_tag,
			           out_mode_bits:  rdata_s1.mode_bits,
			           out_owner_id:   rdata_s1.owner_id,
			           drain_cause:    cause_q,
			           last_of_drain:  is_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbq_pkg::ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			cause_q     <= cbq_pkg::CAUSE_FULL;
			min_q       <= cbq_pkg::BatchNone;
			min_acc_q   <= cbq_pkg::BatchNone;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				cbq_pkg::ST_IDLE: begin
					idx_q     <= '0;
					cause_q   <= cbq_pkg::CAUSE_FULL;
					min_acc_q <= cbq_pkg::BatchNone;
				end
				cbq_pkg::ST_INSERT: begin
					count_q <= count_q + CNT_W'(1);
					min_q   <= ins_min;
					idx_q   <= '0;
					cause_q <= cbq_pkg::CAUSE_SIZE;
				end
				cbq_pkg::ST_DRAIN: begin
					if (out_free) begin
						idx_q <= idx_next;
						if (is_last) begin
							count_q <= '0;
							min_q   <= cbq_pkg::BatchNone;
						end
					end
				end
				cbq_pkg::ST_SCAN: begin
					if (scan_hit) begin
						idx_q   <= '0;
						cause_q <= cbq_pkg::CAUSE_TIME;
					end else begin
						idx_q <= idx_next;
					end
				end
				cbq_pkg::ST_DROP_CHK: begin
					if (drop_match) begin
						if (is_last) begin
							count_q <= cnt_last;
							min_q   <= min_acc_q;
						end
					end else begin
						// survivor: fold its threshold into the new minimum
						min_acc_q <= drop_min;
						idx_q     <= idx_next;
						if (is_last) begin
							min_q <= drop_min;
						end
					end
				end
				cbq_pkg::ST_DROP_MOV: begin
					count_q <= cnt_last;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	assign req_stall = (state_q != cbq_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/cbq_checker.sv
// ----------------------------------------------------------------------------
// cbq_checker
// Port-level checks of the coalescing batch queue: result channel hold,
// drain run consistency and run length, idle after reset, no request mid-run.
// ----------------------------------------------------------------------------
module cbq_checker #(
	parameter int QUEUE_DEPTH = cbq_pkg::QueueDepthDefault
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input cbq_pkg::rsp_t rsp
);

	localparam int RUN_W = $clog2(QUEUE_DEPTH + 1);

	logic             in_run_q;
	logic [1:0]       run_cause_q;
	logic [RUN_W-1:0] run_cnt_q;
	logic             rsp_xfer;

	assign rsp_xfer = rsp_valid && !rsp_stall;

	// track the drain run that is in progress on the result side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q    <= 1'b0;
			run_cause_q <= '0;
			run_cnt_q   <= '0;
		end else if (rsp_xfer) begin
			in_run_q    <= !rsp.last_of_drain;
			run_cause_q <= rsp.drain_cause;
			run_cnt_q   <= rsp.last_of_drain ? '0 : run_cnt_q + RUN_W'(1);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_run_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && in_run_q |-> rsp.drain_cause == run_cause_q)
		else $error("drain cause changed within a run");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> run_cnt_q < RUN_W'(QUEUE_DEPTH)
		&& (run_cnt_q != RUN_W'(QUEUE_DEPTH - 1) || rsp.last_of_drain))
		else $error("drain run longer than the queue");

	a_idle_after_reset: assert property (@(posedge clk)
		!arst_n |=> !req_stall)
		else $error("request side stalled right after reset");

	a_no_req_during_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer && !rsp.last_of_drain && req_valid |-> req_stall)
		else $error("request taken in the middle of a drain run");

endmodule

bind coalescing_batch_queue_core cbq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_cbq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
